### hdl/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre implies post, sampled on the rising clock edge, off while in reset
`define CHK_IMPLY(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("implication check failed");

// cond must never be seen outside reset
`define CHK_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

### hdl/frss_pkg.sv
package frss_pkg;

	localparam int TIME_WIDTH = 32;                  // timer width, 16 to 64
	localparam int DIV_W = 27;                       // holds the numerator
	localparam int Q_W   = 16;                       // rate value width
	localparam int BCD_W = 16;                       // four BCD digits

	localparam logic [DIV_W-1:0] RATE_NUM   = 27'd100000000;
	localparam logic [Q_W-1:0]   RATE_MAX   = 16'hFFFF;
	// elapsed times below this give a quotient above RATE_MAX
	localparam logic [15:0]      OVER_LIMIT = 16'd1526;
	localparam logic [7:0]       POINT_BIT  = 8'h80;

	typedef struct packed {
		logic [TIME_WIDTH-1:0] start_time;
		logic [TIME_WIDTH-1:0] end_time;
	} operands_t;

	typedef struct packed {
		logic [23:0] low_segments;
		logic [7:0]  high_segments;
		logic        overrange;
	} result_t;

	typedef struct packed {
		logic             valid;
		logic             over;
		logic [DIV_W-1:0] rem;
		logic [DIV_W-1:0] divisor;
		logic [Q_W-1:0]   quot;
	} div_stage_t;

	typedef struct packed {
		logic             valid;
		logic [BCD_W-1:0] bcd;
		logic [Q_W-1:0]   bin;
	} bcd_stage_t;

	// active-low segments, bit 0 = a .. bit 6 = g, point bit set (off)
	function automatic logic [7:0] seg_encode(input logic [3:0] digit);
		logic [7:0] seg;
		case (digit)
			4'd0: seg = 8'hC0;
			4'd1: seg = 8'hF9;
			4'd2: seg = 8'hA4;
			4'd3: seg = 8'hB0;
			4'd4: seg = 8'h99;
			4'd5: seg = 8'h92;
			4'd6: seg = 8'h82;
			4'd7: seg = 8'hF8;
			4'd8: seg = 8'h80;
			4'd9: seg = 8'h90;
			default: seg = 8'hFF;
		endcase
		return seg | POINT_BIT;
	endfunction

endpackage

### hdl/frame_rate_seven_segment_core.sv
// Frame-rate to seven-segment encoder: one transfer per cycle, busy never rises.
// result_valid is registered through one input stage, 16 division cells,
// 16 BCD cells and one output register.
// Throughput: one item per clock; the receiver cannot stall, nothing backs up.
// The rate is set by the division and BCD cell chains, one cell per clock.
// Reset (arst_n low) clears all valid bits at once; payload is not reset.
module frame_rate_seven_segment_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  frss_pkg::operands_t  operands,
	output logic                 result_valid,
	output frss_pkg::result_t    result
);

	localparam int TIME_WIDTH = frss_pkg::TIME_WIDTH;
	// timestamps are widened so that any TIME_WIDTH from 16 to 64 wraps correctly
	localparam int EXT_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

	logic [EXT_W-1:0]      start_ext;
	logic [EXT_W-1:0]      end_ext;
	logic [EXT_W-1:0]      diff;
	logic [TIME_WIDTH-1:0] elapsed;
	logic [EXT_W-1:0]      elapsed_ext;
	logic                  too_short;
	logic                  too_long;

	frss_pkg::div_stage_t  stage_s1;
	frss_pkg::div_stage_t  div_chain [0:frss_pkg::Q_W];
	frss_pkg::bcd_stage_t  bcd_chain [0:frss_pkg::Q_W];

	logic [frss_pkg::BCD_W-1:0] digits;
	logic                       result_valid_q;
	frss_pkg::result_t          result_q;

	// every cycle is open for a transfer
	assign busy = 1'b0;

	// elapsed time modulo 2^TIME_WIDTH
	assign start_ext   = EXT_W'(operands.start_time);
	assign end_ext     = EXT_W'(operands.end_time);
	assign diff        = end_ext - start_ext;
	assign elapsed     = diff[TIME_WIDTH-1:0];
	assign elapsed_ext = EXT_W'(elapsed);

	// zero and very short frames saturate; very long ones simply give zero
	assign too_short = elapsed < TIME_WIDTH'(frss_pkg::OVER_LIMIT);
	assign too_long  = elapsed_ext >= (EXT_W'(1) << frss_pkg::DIV_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1.valid <= 1'b0;
		end else begin
			stage_s1.valid   <= start & ~busy;
			stage_s1.over    <= too_short;
			stage_s1.rem     <= frss_pkg::RATE_NUM;
			stage_s1.divisor <= too_long ? '1 : elapsed_ext[frss_pkg::DIV_W-1:0];
			stage_s1.quot    <= '0;
		end
	end

	// quotient bits from the top down, one cell per bit
	assign div_chain[0] = stage_s1;

	for (genvar i = 0; i < frss_pkg::Q_W; i++) begin : g_div
		frss_div_cell #(
			.SHIFT(frss_pkg::Q_W - 1 - i)
		) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.prior  (div_chain[i]),
			.stage  (div_chain[i+1])
		);
	end

	// saturation is applied as the rate enters the BCD chain
	always_comb begin
		bcd_chain[0].valid = div_chain[frss_pkg::Q_W].valid;
		bcd_chain[0].bcd   = '0;
		bcd_chain[0].bin   = div_chain[frss_pkg::Q_W].over ? frss_pkg::RATE_MAX
		                                                   : div_chain[frss_pkg::Q_W].quot;
	end

	// the overrange flag rides alongside the BCD cells in a delay line of
	// flags
	logic [frss_pkg::Q_W-1:0] over_line_q;

	always_ff @(posedge clk) begin
		over_line_q <= {over_line_q[frss_pkg::Q_W-2:0], div_chain[frss_pkg::Q_W].over};
	end

	for (genvar i = 0; i < frss_pkg::Q_W; i++) begin : g_bcd
		frss_bcd_cell u_bcd (
			.clk    (clk),
			.arst_n (arst_n),
			.prior  (bcd_chain[i]),
			.stage  (bcd_chain[i+1])
		);
	end

	assign digits = bcd_chain[frss_pkg::Q_W].bcd;

	// segment bytes: point lit on the ones digit of the rate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q         <= bcd_chain[frss_pkg::Q_W].valid;
			result_q.low_segments  <= {frss_pkg::seg_encode(digits[11:8]) & ~frss_pkg::POINT_BIT,
			                           frss_pkg::seg_encode(digits[7:4]),
			                           frss_pkg::seg_encode(digits[3:0])};
			result_q.high_segments <= frss_pkg::seg_encode(digits[15:12]);
			result_q.overrange     <= over_line_q[frss_pkg::Q_W-1];
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

### hdl/frss_div_cell.sv
// One restoring-division step: tries divisor << SHIFT against the remainder.
module frss_div_cell #(
	parameter int SHIFT = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  frss_pkg::div_stage_t   prior,
	output frss_pkg::div_stage_t   stage
);

	localparam int CMP_W = frss_pkg::DIV_W + frss_pkg::Q_W;

	logic [CMP_W-1:0]     shifted;
	logic [CMP_W-1:0]     rem_ext;
	frss_pkg::div_stage_t step;
	frss_pkg::div_stage_t stage_q;

	always_comb begin
		shifted = CMP_W'(prior.divisor) << SHIFT;
		rem_ext = CMP_W'(prior.rem);
		step    = prior;
		if (rem_ext >= shifted) begin
			step.rem         = prior.rem - shifted[frss_pkg::DIV_W-1:0];
			step.quot[SHIFT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q.valid <= 1'b0;
		end else begin
			stage_q <= step;
		end
	end

	assign stage = stage_q;

endmodule

### hdl/frss_bcd_cell.sv
// One double-dabble step, keeping the low four BCD digits.
module frss_bcd_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  frss_pkg::bcd_stage_t   prior,
	output frss_pkg::bcd_stage_t   stage
);

	logic [frss_pkg::BCD_W-1:0] adj;
	frss_pkg::bcd_stage_t       step;
	frss_pkg::bcd_stage_t       stage_q;

	always_comb begin
		for (int n = 0; n < frss_pkg::BCD_W / 4; n++) begin
			if (prior.bcd[n*4 +: 4] >= 4'd5) begin
				adj[n*4 +: 4] = prior.bcd[n*4 +: 4] + 4'd3;
			end else begin
				adj[n*4 +: 4] = prior.bcd[n*4 +: 4];
			end
		end
		step.valid = prior.valid;
		step.bcd   = {adj[frss_pkg::BCD_W-2:0], prior.bin[frss_pkg::Q_W-1]};
		step.bin   = {prior.bin[frss_pkg::Q_W-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q.valid <= 1'b0;
		end else begin
			stage_q <= step;
		end
	end

	assign stage = stage_q;

endmodule

### hdl/frss_checker.sv
`include "assert_macros.svh"

module frss_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               result_valid,
	input  frss_pkg::result_t  result
);

	// point bits: off everywhere but the ones digit of the rate
	`CHK_NEVER(a_point_bits, clk, arst_n, result_valid && (!result.high_segments[7] || result.low_segments[23] || !result.low_segments[15] || !result.low_segments[7]))

	// a saturated rate always shows 55.35
	`CHK_IMPLY(a_saturated_face, clk, arst_n, result_valid && result.overrange, result.low_segments == 24'h12B092 && result.high_segments == 8'h92)

	// every transfer is followed by its result
	`CHK_IMPLY(a_latency_fwd, clk, arst_n, start && !busy, ##34 result_valid)

	// and no result appears without such a transfer
	`CHK_IMPLY(a_latency_back, clk, arst_n, result_valid, $past(start && !busy, 34))

endmodule

bind frame_rate_seven_segment_core frss_checker u_frss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);

### test/frame_rate_seven_segment_core_test.sv
module frame_rate_seven_segment_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	// allow a margin beyond the pipeline depth once the last display is in
	localparam int PIPE_DEPTH  = 34;
	localparam int SETTLE_WAIT = PIPE_DEPTH + 16;
	// cycles with no transfer on either side before the run is called hung
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_READINGS = 600;
	localparam int CALM_TAIL       = 80;

	// active-low digit patterns, bit 0 = a .. bit 6 = g, point bit set (off)
	localparam logic [7:0] DIGIT_SEGS [10] = '{
		8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
	};

	// one pair of timer readings waiting to go out
	typedef struct {
		frss_pkg::operands_t ops;
		bit                  settle;  // hold off until every display due has come back
		bit                  calm;    // no gaps may precede this one
	} reading_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	frss_pkg::operands_t operands = '0;
	logic                result_valid;
	frss_pkg::result_t   result;

	reading_t          readings_todo [$];
	frss_pkg::result_t displays_due [$];
	int                bad_displays = 0;
	int                gap_left = 0;
	int                quiet_cycles = 0;

	frame_rate_seven_segment_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operands     (operands),
		.result_valid (result_valid),
		.result       (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Frame rate x100 from the elapsed microseconds, split into four decimal
	// digits (ten-thousands dropped) and mapped to segment bytes.
	function automatic frss_pkg::result_t predict_display(frss_pkg::operands_t ops);
		logic [31:0]       elapsed;
		logic [31:0]       quotient;
		logic [31:0]       rate;
		logic              sat;
		logic [7:0]        seg_hundredths, seg_tenths, seg_ones, seg_tens;
		frss_pkg::result_t shown;
		elapsed = ops.end_time - ops.start_time;  // wraps mod 2^32
		sat = 1'b0;
		if (elapsed == 32'd0) begin
			rate = 32'(frss_pkg::RATE_MAX);
			sat = 1'b1;
		end else begin
			quotient = 32'd100000000 / elapsed;
			if (quotient > 32'(frss_pkg::RATE_MAX)) begin
				rate = 32'(frss_pkg::RATE_MAX);
				sat = 1'b1;
			end else begin
				rate = quotient;
			end
		end
		seg_hundredths = DIGIT_SEGS[rate % 10] | frss_pkg::POINT_BIT;
		seg_tenths     = DIGIT_SEGS[(rate / 10) % 10] | frss_pkg::POINT_BIT;
		// point lit after the whole part
		seg_ones       = DIGIT_SEGS[(rate / 100) % 10] & ~frss_pkg::POINT_BIT;
		seg_tens       = DIGIT_SEGS[(rate / 1000) % 10] | frss_pkg::POINT_BIT;
		shown.low_segments  = {seg_ones, seg_tenths, seg_hundredths};
		shown.high_segments = seg_tens;
		shown.overrange     = sat;
		return shown;
	endfunction

	task automatic add_reading(logic [31:0] t0, logic [31:0] t1, bit settle = 1'b0,
			bit calm = 1'b0);
		reading_t r;
		r.ops.start_time = t0;
		r.ops.end_time   = t1;
		r.settle         = settle;
		r.calm           = calm;
		readings_todo.push_back(r);
	endtask

	task automatic report_bad(string why, frss_pkg::result_t want, frss_pkg::result_t got);
		bad_displays++;
		if (bad_displays <= 10)
			$display("%0t: %s: low exp %06h got %06h, high exp %02h got %02h, over exp %0b got %0b",
				$realtime, why, want.low_segments, got.low_segments,
				want.high_segments, got.high_segments, want.overrange, got.overrange);
	endtask

	// Driver: head of the queue sits on the bus until its transfer is taken.
	always @(posedge clk) begin : drive
		bit took;
		took = start && !busy;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (took)
				void'(readings_todo.pop_front());
			if (start && busy) begin
				// held off: keep the same reading on the bus
			end else if (readings_todo.size() == 0) begin
				start <= 1'b0;
			end else if (gap_left != 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (readings_todo[0].settle && (took || displays_due.size() != 0)) begin
				// pipeline must run dry first
				start <= 1'b0;
			end else if (!readings_todo[0].calm && $urandom_range(0, 5) == 0) begin
				// random gap: this cycle and gap_left further ones stay idle
				gap_left = $urandom_range(0, 2);
				start <= 1'b0;
			end else begin
				start    <= 1'b1;
				operands <= readings_todo[0].ops;
			end
		end
	end

	// Monitor: results checked before this edge's transfer is predicted, so the
	// expected display store is only written here.
	always @(posedge clk) begin : watch
		frss_pkg::result_t want;
		if (arst_n) begin
			if (result_valid) begin
				if (displays_due.size() == 0) begin
					report_bad("display with nothing due", '0, result);
				end else begin
					want = displays_due.pop_front();
					if (want.low_segments !== result.low_segments ||
							want.high_segments !== result.high_segments ||
							want.overrange !== result.overrange)
						report_bad("display differs", want, result);
				end
			end
			if (start && !busy)
				displays_due.push_back(predict_display(operands));
		end
	end

	// Hang guard: counts cycles in which neither side transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("frame_rate_seven_segment_core: mismatch");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] t0;
		logic [31:0] span;
		int          kind;

		// directed: saturation, the 1526 us boundary, wrap, digit extremes
		add_reading(32'h0000_0000, 32'h0000_0000);             // zero elapsed
		add_reading(32'hFFFF_FFFF, 32'hFFFF_FFFF);             // zero elapsed, all ones
		add_reading(32'h0000_0000, 32'h0000_0001);             // saturates
		add_reading(32'h0000_1000, 32'h0000_1000 + 32'd1525);  // just over the limit
		add_reading(32'h0000_1000, 32'h0000_1000 + 32'd1526);  // 65530, top digit dropped
		add_reading(32'h0000_0000, 32'd1527);
		add_reading(32'h0000_0000, 32'd10000);                 // 10000 -> shows 00.00
		add_reading(32'h0000_0000, 32'd1667);                  // 59988
		add_reading(32'h0000_0000, 32'd3333);                  // 30003
		add_reading(32'h0000_0000, 32'd11111);                 // 9000
		add_reading(32'h0000_0000, 32'd12346);                 // 8099
		add_reading(32'h0000_0000, 32'd40000);                 // 2500
		add_reading(32'h0000_0000, 32'd100000000);             // rate 1
		add_reading(32'h0000_0000, 32'd100000001);             // rate 0
		add_reading(32'h0000_0000, 32'hFFFF_FFFF);             // longest span
		add_reading(32'hFFFF_FFF0, 32'h0000_0010);             // wrap, saturates
		add_reading(32'hFFFF_0000, 32'h0000_1000);             // wrap, 69632 us
		add_reading(32'hAAAA_AAAA, 32'h5555_5555);
		add_reading(32'h5555_5555, 32'hAAAA_AAAA);
		add_reading(32'h8000_0000, 32'h8000_0000 + 32'd60000, 1'b1);
		add_reading(32'h7FFF_FFFF, 32'h8000_0000 + 32'd1999);

		// random: spans weighted towards the ranges that move the digits
		for (int i = 0; i < RANDOM_READINGS; i++) begin
			t0   = $urandom;
			kind = $urandom_range(0, 9);
			case (kind)
				0: span = $urandom_range(0, 2000);
				1, 2, 3: span = $urandom_range(1500, 20000);
				4, 5: span = $urandom_range(20000, 1000000);
				6, 7: span = $urandom_range(1000000, 110000000);
				default: span = $urandom;
			endcase
			add_reading(t0, t0 + span, i == RANDOM_READINGS / 2,
				i >= RANDOM_READINGS - CALM_TAIL);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (readings_todo.size() != 0 || displays_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);

		if (bad_displays == 0 && displays_due.size() == 0) begin
			$display("frame_rate_seven_segment_core: match");
		end else begin
			$display("frame_rate_seven_segment_core: mismatch");
		end
		$finish;
	end

endmodule
